/* rtl/core/md5sh_pkg.sv */
// Package for the MD5 stream hasher: word types, function codes, round
// constants and the microcode ROM of the sequencer.
// No dependencies.
package md5sh_pkg;

   // Request and response words
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Four 32-bit words (chaining or working set), index 0 is A
   typedef logic [3:0][31:0] word4_type;

   // Controls from the sequencer into the round datapath
   typedef struct packed {
      logic load;
      logic phase_a;
      logic phase_b;
   } rnd_ctl_type;

   // Request function codes
   localparam logic [1:0] FUNC_ABSORB        = 2'd0;
   localparam logic [1:0] FUNC_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] FUNC_FINISH        = 2'd2;
   localparam logic [1:0] FUNC_NONE          = 2'd3;

   // Initial chaining values
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'h3f;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [3:0] LEN_LO_WORD = 4'd14;
   localparam logic [3:0] LEN_HI_WORD = 4'd15;

   // Per-round additive constants
   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amount for a round
   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      logic [4:0] s;
      case ({rnd[5:4], rnd[1:0]})
         4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
         4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
         4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
         4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
      endcase
      return s;
   endfunction

   // Message word picked by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] i;
      logic [3:0] g;
      i = rnd[3:0];
      case (rnd[5:4])
         2'd0:    g = i;
         2'd1:    g = (i << 2) + i + 4'd1;
         2'd2:    g = (i << 1) + i + 4'd5;
         default: g = (i << 3) - i;
      endcase
      return g;
   endfunction

   // Microcode: datapath operations
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_ACCEPT = 4'd1;
   localparam logic [3:0] OP_PAD80  = 4'd2;
   localparam logic [3:0] OP_PADZ   = 4'd3;
   localparam logic [3:0] OP_LEN_LO = 4'd4;
   localparam logic [3:0] OP_LEN_HI = 4'd5;
   localparam logic [3:0] OP_EMIT   = 4'd6;
   localparam logic [3:0] OP_INIT   = 4'd7;
   localparam logic [3:0] OP_LOAD   = 4'd8;
   localparam logic [3:0] OP_RND_A  = 4'd9;
   localparam logic [3:0] OP_RND_B  = 4'd10;
   localparam logic [3:0] OP_ADD    = 4'd11;

   // Microcode: jump conditions
   localparam logic [3:0] C_NEXT      = 4'd0;  // never jump
   localparam logic [3:0] C_ALWAYS    = 4'd1;
   localparam logic [3:0] C_IDLE      = 4'd2;  // no word taken, or unused func
   localparam logic [3:0] C_FUNC2     = 4'd3;
   localparam logic [3:0] C_FULL      = 4'd4;  // absorbed byte filled the block
   localparam logic [3:0] C_FUNC0     = 4'd5;
   localparam logic [3:0] C_WRAP      = 4'd6;  // pad byte lands in last slot
   localparam logic [3:0] C_PTR56     = 4'd7;
   localparam logic [3:0] C_EMIT_MORE = 4'd8;
   localparam logic [3:0] C_RND_MORE  = 4'd9;
   localparam logic [3:0] C_RET       = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] cond;
      logic       link;
      logic [3:0] target;
   } ctrl_word_type;

   // Program entry points
   localparam logic [3:0] PC_WAIT  = 4'd0;
   localparam logic [3:0] PC_PAD   = 4'd4;
   localparam logic [3:0] PC_ZLOOP = 4'd5;
   localparam logic [3:0] PC_LEN   = 4'd8;
   localparam logic [3:0] PC_EMIT  = 4'd10;
   localparam logic [3:0] PC_COMP  = 4'd12;
   localparam logic [3:0] PC_ROUND = 4'd13;

   function automatic ctrl_word_type cw(input logic [3:0] op, input logic [3:0] cond,
                                        input logic link, input logic [3:0] target);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.link   = link;
      w.target = target;
      return w;
   endfunction

   // Microcode ROM
   function automatic ctrl_word_type ucode(input logic [3:0] pc);
      ctrl_word_type w;
      case (pc)
         4'd0:    w = cw(OP_ACCEPT, C_IDLE,      1'b0, PC_WAIT);
         4'd1:    w = cw(OP_NOP,    C_FUNC2,     1'b0, PC_PAD);
         4'd2:    w = cw(OP_NOP,    C_FULL,      1'b1, PC_COMP);
         4'd3:    w = cw(OP_NOP,    C_FUNC0,     1'b0, PC_WAIT);
         4'd4:    w = cw(OP_PAD80,  C_WRAP,      1'b1, PC_COMP);
         4'd5:    w = cw(OP_NOP,    C_PTR56,     1'b0, PC_LEN);
         4'd6:    w = cw(OP_PADZ,   C_WRAP,      1'b1, PC_COMP);
         4'd7:    w = cw(OP_NOP,    C_ALWAYS,    1'b0, PC_ZLOOP);
         4'd8:    w = cw(OP_LEN_LO, C_NEXT,      1'b0, PC_WAIT);
         4'd9:    w = cw(OP_LEN_HI, C_ALWAYS,    1'b1, PC_COMP);
         4'd10:   w = cw(OP_EMIT,   C_EMIT_MORE, 1'b0, PC_EMIT);
         4'd11:   w = cw(OP_INIT,   C_ALWAYS,    1'b0, PC_WAIT);
         4'd12:   w = cw(OP_LOAD,   C_NEXT,      1'b0, PC_WAIT);
         4'd13:   w = cw(OP_RND_A,  C_NEXT,      1'b0, PC_WAIT);
         4'd14:   w = cw(OP_RND_B,  C_RND_MORE,  1'b0, PC_ROUND);
         default: w = cw(OP_ADD,    C_RET,       1'b0, PC_WAIT);
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/md5sh_round.sv */
// MD5 round datapath: working words A..D, round counter and the split
// round step (sum, then rotate and add). Depends on md5sh_pkg.
module md5sh_round (
   input  logic                    clock,
   input  logic                    reset,
   input  md5sh_pkg::rnd_ctl_type  ctl,
   input  md5sh_pkg::word4_type    chain,
   input  logic [31:0]             msg_word,
   output md5sh_pkg::word4_type    work,
   output logic [5:0]              rnd_idx,
   output logic                    rnd_more
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] sum_ff, sum_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] f_val;
   logic [63:0] rot_wide;
   logic [31:0] t_val;

   // Round function by group
   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
   end

   // Rotate the stored sum and add B
   assign rot_wide = {sum_ff, sum_ff} << md5sh_pkg::rot_amount(rnd_ff);
   assign t_val    = rot_wide[63:32] + b_ff;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      sum_in = sum_ff;
      rnd_in = rnd_ff;
      if (ctl.load) begin
         a_in   = chain[0];
         b_in   = chain[1];
         c_in   = chain[2];
         d_in   = chain[3];
         rnd_in = '0;
      end else if (ctl.phase_a) begin
         sum_in = a_ff + f_val + msg_word + md5sh_pkg::K_TABLE[rnd_ff];
      end else if (ctl.phase_b) begin
         a_in   = d_ff;
         d_in   = c_ff;
         c_in   = b_ff;
         b_in   = t_val;
         rnd_in = rnd_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
      end else begin
         rnd_ff <= rnd_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
   end

   assign work     = {d_ff, c_ff, b_ff, a_ff};
   assign rnd_idx  = rnd_ff;
   assign rnd_more = (rnd_ff != md5sh_pkg::LAST_ROUND);

endmodule

/* rtl/core/md5_stream_hasher_top.sv */
// MD5 stream hasher top level: microcoded sequencer, block buffer,
// chaining words, byte count and digest output. Depends on md5sh_pkg
// and md5sh_round.
//
// The hasher takes one message byte per request word and returns the
// 16-byte MD5 digest as four response words after a finish request. An
// absorb that completes a 64-byte block adds a compression (a load, the
// 64 rounds, each split into a sum step and a rotate-and-add step, and a
// chaining add), during which no request is taken; this bounds
// throughput on long messages. A finish writes the 0x80 byte, then each
// zero pad byte (check, write, loop back), then the two length words,
// compresses once (twice when fewer than 9 bytes were left in the block)
// and then presents the four digest words, one per cycle while the
// consumer does not stall. All work is done by a 16-step microprogram
// driving one shared round unit; the next request is taken once the
// sequencer is back at its wait step, even while the last digest word
// still sits in the output register.
module md5_stream_hasher_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  md5sh_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output md5sh_pkg::rsp_type rsp_data
);

   // Sequencer
   logic [3:0]               step_ff, step_in;
   logic [3:0]               ret_ff, ret_in;
   md5sh_pkg::ctrl_word_type ctrl;
   logic                     take;
   logic [3:0]               step_next;

   // Request context
   logic [1:0]  func_ff, func_in;
   logic        full_ff, full_in;
   logic        req_go;
   logic        absorb;

   // Message state
   logic [60:0] count_ff, count_in;
   logic [5:0]  ptr_ff, ptr_in;
   logic [31:0] block_ff [16];
   logic [31:0] block_in [16];
   md5sh_pkg::word4_type chain_ff, chain_in;

   // Buffer write port
   logic        wr_en;
   logic [3:0]  wr_idx;
   logic [3:0]  wr_be;
   logic [31:0] wr_data;
   logic [3:0]  lane_be;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   md5sh_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0]         emit_idx_ff, emit_idx_in;
   logic               emit_load;

   // Round unit
   md5sh_pkg::rnd_ctl_type rctl;
   md5sh_pkg::word4_type   work;
   logic [5:0]             rnd_idx;
   logic                   rnd_more;
   logic [31:0]            msg_word;

   assign ctrl      = md5sh_pkg::ucode(step_ff);
   assign req_stall = (ctrl.op != md5sh_pkg::OP_ACCEPT);
   assign req_go    = req_valid && !req_stall;
   assign absorb    = req_go && (req_data.func == md5sh_pkg::FUNC_ABSORB ||
                                 req_data.func == md5sh_pkg::FUNC_ABSORB_FINISH);
   assign emit_load = (ctrl.op == md5sh_pkg::OP_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Jump condition
   always_comb begin
      case (ctrl.cond)
         md5sh_pkg::C_NEXT:      take = 1'b0;
         md5sh_pkg::C_ALWAYS:    take = 1'b1;
         md5sh_pkg::C_IDLE:      take = !req_valid || (req_data.func == md5sh_pkg::FUNC_NONE);
         md5sh_pkg::C_FUNC2:     take = (func_ff == md5sh_pkg::FUNC_FINISH);
         md5sh_pkg::C_FULL:      take = full_ff;
         md5sh_pkg::C_FUNC0:     take = (func_ff == md5sh_pkg::FUNC_ABSORB);
         md5sh_pkg::C_WRAP:      take = (ptr_ff == md5sh_pkg::LAST_POS);
         md5sh_pkg::C_PTR56:     take = (ptr_ff == md5sh_pkg::LEN_POS);
         md5sh_pkg::C_EMIT_MORE: take = !(emit_load && emit_idx_ff == 2'd3);
         md5sh_pkg::C_RND_MORE:  take = rnd_more;
         md5sh_pkg::C_RET:       take = 1'b1;
         default:                take = 1'b0;
      endcase
   end

   // Step counter with one-level call and return
   assign step_next = step_ff + 4'd1;

   always_comb begin
      step_in = step_next;
      ret_in  = ret_ff;
      if (take) begin
         step_in = (ctrl.cond == md5sh_pkg::C_RET) ? ret_ff : ctrl.target;
         if (ctrl.link) begin
            ret_in = step_next;
         end
      end
   end

   // Request context, byte count and pad pointer
   always_comb begin
      func_in  = func_ff;
      full_in  = full_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (req_go) begin
         func_in = req_data.func;
         full_in = absorb && (ptr_ff == md5sh_pkg::LAST_POS);
      end
      if (absorb) begin
         count_in = count_ff + 61'd1;
         ptr_in   = ptr_ff + 6'd1;
      end
      case (ctrl.op)
         md5sh_pkg::OP_PAD80,
         md5sh_pkg::OP_PADZ: ptr_in = ptr_ff + 6'd1;
         md5sh_pkg::OP_INIT: begin
            count_in = '0;
            ptr_in   = '0;
         end
         default: ;
      endcase
   end

   // Block buffer write port
   assign lane_be = 4'b0001 << ptr_ff[1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = ptr_ff[5:2];
      wr_be   = lane_be;
      wr_data = '0;
      case (ctrl.op)
         md5sh_pkg::OP_ACCEPT: begin
            wr_en   = absorb;
            wr_data = {4{req_data.data_byte}};
         end
         md5sh_pkg::OP_PAD80: begin
            wr_en   = 1'b1;
            wr_data = {4{md5sh_pkg::PAD_BYTE}};
         end
         md5sh_pkg::OP_PADZ: begin
            wr_en = 1'b1;
         end
         md5sh_pkg::OP_LEN_LO: begin
            wr_en   = 1'b1;
            wr_idx  = md5sh_pkg::LEN_LO_WORD;
            wr_be   = 4'hf;
            wr_data = {count_ff[28:0], 3'b000};
         end
         md5sh_pkg::OP_LEN_HI: begin
            wr_en   = 1'b1;
            wr_idx  = md5sh_pkg::LEN_HI_WORD;
            wr_be   = 4'hf;
            wr_data = count_ff[60:29];
         end
         default: ;
      endcase
   end

   always_comb begin
      for (int w = 0; w < 16; w++) begin
         block_in[w] = block_ff[w];
         for (int l = 0; l < 4; l++) begin
            if (wr_en && wr_idx == w[3:0] && wr_be[l]) begin
               block_in[w][8*l +: 8] = wr_data[8*l +: 8];
            end
         end
      end
   end

   // Message word for the current round
   assign msg_word = block_ff[md5sh_pkg::msg_index(rnd_idx)];

   // Round unit controls
   assign rctl.load    = (ctrl.op == md5sh_pkg::OP_LOAD);
   assign rctl.phase_a = (ctrl.op == md5sh_pkg::OP_RND_A);
   assign rctl.phase_b = (ctrl.op == md5sh_pkg::OP_RND_B);

   md5sh_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rctl),
      .chain    (chain_ff),
      .msg_word (msg_word),
      .work     (work),
      .rnd_idx  (rnd_idx),
      .rnd_more (rnd_more)
   );

   // Chaining words
   always_comb begin
      chain_in = chain_ff;
      case (ctrl.op)
         md5sh_pkg::OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + work[i];
            end
         end
         md5sh_pkg::OP_INIT: begin
            chain_in = {md5sh_pkg::IV_D, md5sh_pkg::IV_C, md5sh_pkg::IV_B, md5sh_pkg::IV_A};
         end
         default: ;
      endcase
   end

   // Digest output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.digest_word = chain_ff[emit_idx_ff];
         rsp_data_in.word_index  = emit_idx_ff;
         rsp_data_in.last_word   = (emit_idx_ff == 2'd3);
         emit_idx_in             = emit_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= md5sh_pkg::PC_WAIT;
         ret_ff       <= md5sh_pkg::PC_WAIT;
         func_ff      <= md5sh_pkg::FUNC_NONE;
         full_ff      <= 1'b0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         chain_ff     <= {md5sh_pkg::IV_D, md5sh_pkg::IV_C, md5sh_pkg::IV_B, md5sh_pkg::IV_A};
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         step_ff      <= step_in;
         ret_ff       <= ret_in;
         func_ff      <= func_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
      rsp_data_ff <= rsp_data_in;
      block_ff    <= block_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* dv/md5_stream_hasher_checker.sv */
// Checker for the MD5 stream hasher: watches the request and response channels,
// predicts the digest words from the accepted byte stream and compares them.
// Depends on md5sh_pkg for the channel word types and function codes.
module md5_stream_hasher_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  md5sh_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  md5sh_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Per-round additive constants, floor(abs(sin(i + 1)) * 2^32)
   localparam logic [31:0] SINE_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, four per group of sixteen rounds
   localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

   logic [31:0]        chain_q [4];
   logic [31:0]        blk_q [16];
   logic [60:0]        nbytes;
   md5sh_pkg::rsp_type expected_words [$];
   md5sh_pkg::rsp_type want;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Fresh message: initial chaining words, empty byte count
   function automatic void restart_chain();
      chain_q[0] = 32'h67452301;
      chain_q[1] = 32'hefcdab89;
      chain_q[2] = 32'h98badcfe;
      chain_q[3] = 32'h10325476;
      nbytes     = '0;
   endfunction

   // 64 rounds over the block buffer, folded into the chaining words
   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t;
      int          g;
      int          i;
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      for (i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + blk_q[g] + SINE_ADD[i];
         t = rol32(t, ROT_AMT[(i / 16) * 4 + i % 4]) + b;
         a = d;
         d = c;
         c = b;
         b = t;
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
   endfunction

   // Little-endian byte lane write; the last slot closes the block
   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] value);
      blk_q[pos[5:2]][8 * pos[1:0] +: 8] = value;
      if (pos == 6'h3f) begin
         md5_compress();
      end
   endfunction

   // Pad, append bit length, queue the four digest words, start over
   function automatic void close_message();
      logic [63:0]        bitlen;
      logic [5:0]         p;
      md5sh_pkg::rsp_type w;
      int                 i;
      bitlen = {nbytes, 3'b000};
      p = nbytes[5:0];
      place_byte(p, 8'h80);
      p = p + 6'd1;
      while (p != 6'd56) begin
         place_byte(p, 8'h00);
         p = p + 6'd1;
      end
      for (i = 0; i < 8; i++) begin
         place_byte(6'(56 + i), bitlen[8 * i +: 8]);
      end
      for (i = 0; i < 4; i++) begin
         w.digest_word = chain_q[i];
         w.word_index  = 2'(i);
         w.last_word   = (i == 3);
         expected_words.push_back(w);
      end
      restart_chain();
   endfunction

   task automatic log_mismatch(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t %s: expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
                  $realtime, what, want.digest_word, want.word_index, want.last_word,
                  rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
      end
   endtask

   // Responses are checked before the request of the same edge is absorbed
   always @(posedge clock) begin
      if (reset) begin
         restart_chain();
         expected_words.delete();
         fail_count    = 0;
         words_pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               want = '0;
               log_mismatch("digest word with none due");
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word ||
                   rsp_data.word_index !== want.word_index ||
                   rsp_data.last_word !== want.last_word) begin
                  log_mismatch("digest word mismatch");
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.func)
               md5sh_pkg::FUNC_ABSORB: begin
                  place_byte(nbytes[5:0], req_data.data_byte);
                  nbytes = nbytes + 61'd1;
               end
               md5sh_pkg::FUNC_ABSORB_FINISH: begin
                  place_byte(nbytes[5:0], req_data.data_byte);
                  nbytes = nbytes + 61'd1;
                  close_message();
               end
               md5sh_pkg::FUNC_FINISH: begin
                  close_message();
               end
               default: begin
                  // unused code: no state change, no digest
               end
            endcase
         end
         words_pending = expected_words.size();
      end
   end

endmodule

/* dv/md5_stream_hasher_top_test.sv */
// Testbench top for the MD5 stream hasher: clock, reset, byte stream stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on md5sh_pkg, md5_stream_hasher_top and md5_stream_hasher_checker.
module md5_stream_hasher_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int STALL_PCT      = 32;
   localparam int ITEM_TARGET    = 140;
   localparam int CALM_FIRST     = 50;
   localparam int CALM_LAST      = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   md5sh_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   md5sh_pkg::rsp_type rsp_data;
   int                 fail_count;
   int                 words_pending;

   logic     calm = 1'b0;
   logic     hold_armed = 1'b0;
   int       items_sent = 0;

   md5_stream_hasher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   md5_stream_hasher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Offer one request word, idling now and then; returns at its accepting edge
   task automatic offer_word(input logic [1:0] func, input logic [7:0] value);
      md5sh_pkg::req_type w;
      // No idling on either side over one stretch of the stream
      calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w.func      = func;
      w.data_byte = value;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Sender stays quiet until every predicted digest word has come back
   task automatic await_digests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin
      int msg;
      int pick;
      int msg_len;
      int i;
      logic close_with_byte;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty message right after reset; the byte of a finish-only word is ignored
      offer_word(md5sh_pkg::FUNC_FINISH, 8'ha5);
      // "abc", closed by absorb-and-finish
      offer_word(md5sh_pkg::FUNC_ABSORB, 8'h61);
      offer_word(md5sh_pkg::FUNC_ABSORB, 8'h62);
      offer_word(md5sh_pkg::FUNC_ABSORB_FINISH, 8'h63);
      // Unused code changes nothing, with either byte extreme
      offer_word(md5sh_pkg::FUNC_NONE, 8'hff);
      offer_word(md5sh_pkg::FUNC_NONE, 8'h00);
      offer_word(md5sh_pkg::FUNC_ABSORB, 8'h00);
      offer_word(md5sh_pkg::FUNC_ABSORB, 8'hff);
      offer_word(md5sh_pkg::FUNC_NONE, 8'h5a);
      offer_word(md5sh_pkg::FUNC_ABSORB_FINISH, 8'hff);
      // Finish-only right after a digest: empty message again, back to back
      offer_word(md5sh_pkg::FUNC_FINISH, 8'h00);
      offer_word(md5sh_pkg::FUNC_FINISH, 8'hff);
      // Single-byte message
      offer_word(md5sh_pkg::FUNC_ABSORB_FINISH, 8'h00);
      // Bit length wrap needs 2^61 bytes and is out of reach here
      await_digests();

      // Random messages: mostly short, many near the 56 and 64 byte edges
      hold_armed = 1'b1;
      msg = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            msg_len = $urandom_range(8);
         end else if (pick < 85) begin
            msg_len = $urandom_range(66, 54);
         end else if (pick < 95) begin
            msg_len = $urandom_range(53, 9);
         end else begin
            msg_len = $urandom_range(130, 67);
         end
         close_with_byte = (msg_len > 0) && ($urandom_range(1) == 1);
         for (i = 0; i < msg_len; i++) begin
            if ($urandom_range(99) < 8) begin
               offer_word(md5sh_pkg::FUNC_NONE, 8'($urandom));
            end
            if (close_with_byte && i == msg_len - 1) begin
               offer_word(md5sh_pkg::FUNC_ABSORB_FINISH, 8'($urandom));
            end else begin
               offer_word(md5sh_pkg::FUNC_ABSORB, 8'($urandom));
            end
         end
         if (!close_with_byte) begin
            offer_word(md5sh_pkg::FUNC_FINISH, 8'($urandom));
         end
         if (msg == 1) begin
            await_digests();
         end
         msg++;
      end
      calm = 1'b0;

      await_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("md5_stream_hasher_top verification clean");
      end else begin
         $display("md5_stream_hasher_top verification failed");
      end
      $finish;
   end

   // Digest consumer: random stalls, one long hold-off while bytes keep coming
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && !hold_done && hold_armed && rsp_valid && req_valid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);
         end
      end
   end

   // Watchdog: too long without any word moving on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("md5_stream_hasher_top verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/md5sh_pkg.sv
rtl/core/md5sh_round.sv
rtl/core/md5_stream_hasher_top.sv
dv/md5_stream_hasher_checker.sv
dv/md5_stream_hasher_top_test.sv
